// ----- sv/pfcm_pkg.sv -----
// Shared types and constants for the program flow checkpoint monitor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfcm_pkg;

  localparam int unsigned NUM_LEN_REGS = 4;
  localparam int unsigned CP_W         = 8;
  localparam int unsigned SEQ_W        = 2;
  localparam int unsigned INST_W       = 2;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  // Length as seen by the wrap logic: a register value of zero means 256.
  localparam int unsigned LEN_W        = 9;

  localparam logic [CP_W-1:0]  LEN_RESET   = 8'd4;
  localparam logic [CP_W-1:0]  CP_ALL_ONES = 8'hFF;
  localparam logic [CP_W-1:0]  CP_ZERO     = 8'h00;
  localparam logic [LEN_W-1:0] LEN_FULL    = 9'd256;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADVANCED     = 3'd0,
    ST_NEW_INSTANCE = 3'd1,
    ST_INTEGRITY    = 3'd2,
    ST_TOO_MANY     = 3'd3,
    ST_WRONG        = 3'd4,
    ST_HALTED       = 3'd5,
    ST_RESTARTED    = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    ACT_CHECKPOINT = 1'b0,
    ACT_RESTART    = 1'b1
  } action_e;

  typedef struct packed {
    status_e             status;
    logic [INST_W-1:0]   active_instance;
    logic [CP_W-1:0]     current_checkpoint;
  } result_t;

  function automatic logic [LEN_W-1:0] len_of(input logic [CP_W-1:0] r);
    return (r == CP_ZERO) ? LEN_FULL : {1'b0, r};
  endfunction

endpackage

`default_nettype wire

// ----- sv/pfcm_rem_unit.sv -----
// Iterative remainder unit: one restoring step per cycle, one step per dividend bit.
// Depends on pfcm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module pfcm_rem_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pfcm_pkg::LEN_W-1:0]    dividend_i,
  input  wire logic [pfcm_pkg::LEN_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [pfcm_pkg::CP_W-1:0]          rem_o
);

  localparam int unsigned W     = pfcm_pkg::LEN_W;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     quo_q, rem_q, div_q;
  logic [W:0]       trial, diff;
  logic [W-1:0]     rem_d;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, div_q};
  // borrow out means the trial value stays
  assign rem_d = diff[W] ? trial[W-1:0] : diff[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(W);
      quo_q  <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[W-2:0], 1'b0};
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  // remainder is below the divisor, which is at most 256
  assign rem_o  = rem_q[pfcm_pkg::CP_W-1:0];

endmodule

`default_nettype wire

// ----- sv/pfcm_core.sv -----
// Checkpoint store with shadow copies, per-entry next-checkpoint cache, step
// decision and the cache refresh sweep. Depends on pfcm_pkg and pfcm_rem_unit.
`timescale 1ns / 1ps
`default_nettype none

module pfcm_core #(
  parameter int unsigned NUM_SEQUENCES = 4,
  parameter int unsigned MAX_PARALLEL  = 4
) (
  input  wire logic                                                   clk_i,
  input  wire logic                                                   rst_ni,
  input  wire logic [pfcm_pkg::NUM_LEN_REGS-1:0][pfcm_pkg::CP_W-1:0]  seq_len_i,
  input  wire logic                                                   cfg_we_i,
  input  wire logic                                                   step_i,
  input  wire logic                                                   action_i,
  input  wire logic [pfcm_pkg::SEQ_W-1:0]                             sequence_id_i,
  input  wire logic [pfcm_pkg::CP_W-1:0]                              checkpoint_id_i,
  output logic                                                        busy_o,
  output pfcm_pkg::result_t                                           result_o
);

  localparam int unsigned SW     = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int unsigned IW     = (MAX_PARALLEL > 1) ? $clog2(MAX_PARALLEL) : 1;
  localparam int unsigned CPW    = pfcm_pkg::CP_W;
  localparam int unsigned LW     = pfcm_pkg::LEN_W;
  localparam int unsigned OUT_IW = pfcm_pkg::INST_W;
  localparam int unsigned STW    = pfcm_pkg::STATUS_W;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_LOAD,
    SW_WAIT
  } sweep_e;

  logic [CPW-1:0] last_q [NUM_SEQUENCES][MAX_PARALLEL];
  logic [CPW-1:0] inv_q  [NUM_SEQUENCES][MAX_PARALLEL];
  logic [CPW-1:0] next_q [NUM_SEQUENCES][MAX_PARALLEL];
  logic [IW-1:0]  idx_q  [NUM_SEQUENCES];
  logic [STW-1:0] err_q;

  sweep_e         sw_state_q;
  logic [SW-1:0]  sw_seq_q;
  logic [IW-1:0]  sw_inst_q;

  logic [CPW-1:0] init_val [NUM_SEQUENCES];

  logic [3:0]     seq_w, sw_seq_w;
  logic           seq_ok;
  logic [SW-1:0]  s_idx;
  logic [IW-1:0]  a, a_inc;
  logic [CPW-1:0] last_a, next_a;
  logic [LW-1:0]  len_cur;
  logic           intact;
  logic [CPW-1:0] adv_next, new_next;
  logic           do_init, do_adv, do_new, set_err;
  pfcm_pkg::status_e status;
  logic [IW-1:0]  act_out;
  logic [CPW-1:0] cur_out;

  logic           rem_done;
  logic [CPW-1:0] rem_val;
  logic [LW-1:0]  sw_dividend, sw_divisor;
  logic           sw_last_entry;

  assign seq_w   = {2'b00, sequence_id_i};
  assign seq_ok  = seq_w < 4'(NUM_SEQUENCES);
  assign s_idx   = seq_ok ? seq_w[SW-1:0] : '0;
  assign a       = idx_q[s_idx];
  assign a_inc   = a + IW'(1);
  assign last_a  = last_q[s_idx][a];
  assign next_a  = next_q[s_idx][a];
  assign len_cur = pfcm_pkg::len_of(seq_len_i[sequence_id_i]);

  // wrap of the value after next; next is already below the length
  assign adv_next = (({1'b0, next_a} + LW'(1)) == len_cur) ? pfcm_pkg::CP_ZERO
                                                          : next_a + CPW'(1);
  assign new_next = (len_cur == LW'(1)) ? pfcm_pkg::CP_ZERO : CPW'(1);

  always_comb begin
    for (int s = 0; s < NUM_SEQUENCES; s++) begin
      init_val[s] = seq_len_i[2'(s)] - CPW'(1);
    end
  end

  always_comb begin
    intact = 1'b1;
    for (int s = 0; s < NUM_SEQUENCES; s++) begin
      for (int i = 0; i < MAX_PARALLEL; i++) begin
        if ((last_q[s][i] ^ inv_q[s][i]) != pfcm_pkg::CP_ALL_ONES) begin
          intact = 1'b0;
        end
      end
    end
  end

  always_comb begin
    do_init = 1'b0;
    do_adv  = 1'b0;
    do_new  = 1'b0;
    set_err = 1'b0;
    status  = pfcm_pkg::ST_HALTED;
    act_out = a;
    cur_out = last_a;
    if (action_i == pfcm_pkg::ACT_RESTART) begin
      do_init = 1'b1;
      status  = pfcm_pkg::ST_RESTARTED;
      act_out = '0;
      cur_out = seq_len_i[sequence_id_i] - CPW'(1);
    end else if (err_q != '0) begin
      status = pfcm_pkg::ST_HALTED;
    end else if (!intact) begin
      status  = pfcm_pkg::ST_INTEGRITY;
      set_err = 1'b1;
    end else if (!seq_ok) begin
      status  = pfcm_pkg::ST_WRONG;
      set_err = 1'b1;
    end else if (checkpoint_id_i == next_a) begin
      do_adv  = 1'b1;
      status  = pfcm_pkg::ST_ADVANCED;
      cur_out = next_a;
    end else if (checkpoint_id_i == pfcm_pkg::CP_ZERO && MAX_PARALLEL > 1) begin
      if (a == IW'(MAX_PARALLEL - 1)) begin
        status  = pfcm_pkg::ST_TOO_MANY;
        set_err = 1'b1;
      end else begin
        do_new  = 1'b1;
        status  = pfcm_pkg::ST_NEW_INSTANCE;
        act_out = a_inc;
        cur_out = pfcm_pkg::CP_ZERO;
      end
    end else begin
      status  = pfcm_pkg::ST_WRONG;
      set_err = 1'b1;
    end
    if (!seq_ok) begin
      act_out = '0;
      cur_out = pfcm_pkg::CP_ZERO;
    end
  end

  assign result_o.status             = status;
  assign result_o.active_instance    = OUT_IW'(act_out);
  assign result_o.current_checkpoint = cur_out;

  // Refresh of the next-checkpoint cache after a length write
  assign sw_seq_w      = 4'(sw_seq_q);
  assign sw_dividend   = {1'b0, last_q[sw_seq_q][sw_inst_q]} + LW'(1);
  assign sw_divisor    = pfcm_pkg::len_of(seq_len_i[sw_seq_w[1:0]]);
  assign sw_last_entry = (sw_seq_q == SW'(NUM_SEQUENCES - 1)) &&
                         (sw_inst_q == IW'(MAX_PARALLEL - 1));

  pfcm_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sw_state_q == SW_LOAD),
    .dividend_i (sw_dividend),
    .divisor_i  (sw_divisor),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SEQUENCES; s++) begin
        idx_q[s] <= '0;
        for (int i = 0; i < MAX_PARALLEL; i++) begin
          last_q[s][i] <= pfcm_pkg::LEN_RESET - CPW'(1);
          inv_q[s][i]  <= ~(pfcm_pkg::LEN_RESET - CPW'(1));
          next_q[s][i] <= pfcm_pkg::CP_ZERO;
        end
      end
      err_q      <= '0;
      sw_state_q <= SW_IDLE;
      sw_seq_q   <= '0;
      sw_inst_q  <= '0;
    end else begin
      if (step_i) begin
        if (do_init) begin
          for (int s = 0; s < NUM_SEQUENCES; s++) begin
            idx_q[s] <= '0;
            for (int i = 0; i < MAX_PARALLEL; i++) begin
              last_q[s][i] <= init_val[s];
              inv_q[s][i]  <= ~init_val[s];
              next_q[s][i] <= pfcm_pkg::CP_ZERO;
            end
          end
          err_q <= '0;
        end
        if (do_adv) begin
          last_q[s_idx][a] <= next_a;
          inv_q[s_idx][a]  <= ~next_a;
          next_q[s_idx][a] <= adv_next;
        end
        if (do_new) begin
          idx_q[s_idx]         <= a_inc;
          last_q[s_idx][a_inc] <= pfcm_pkg::CP_ZERO;
          inv_q[s_idx][a_inc]  <= pfcm_pkg::CP_ALL_ONES;
          next_q[s_idx][a_inc] <= new_next;
        end
        if (set_err) begin
          err_q <= status;
        end
      end

      if (cfg_we_i) begin
        sw_state_q <= SW_LOAD;
        sw_seq_q   <= '0;
        sw_inst_q  <= '0;
      end else begin
        case (sw_state_q)
          SW_IDLE: ;
          SW_LOAD: sw_state_q <= SW_WAIT;
          SW_WAIT: begin
            if (rem_done) begin
              next_q[sw_seq_q][sw_inst_q] <= rem_val;
              if (sw_last_entry) begin
                sw_state_q <= SW_IDLE;
              end else begin
                sw_state_q <= SW_LOAD;
                if (sw_inst_q == IW'(MAX_PARALLEL - 1)) begin
                  sw_inst_q <= '0;
                  sw_seq_q  <= sw_seq_q + SW'(1);
                end else begin
                  sw_inst_q <= sw_inst_q + IW'(1);
                end
              end
            end
          end
          default: sw_state_q <= SW_IDLE;
        endcase
      end
    end
  end

  assign busy_o = (sw_state_q != SW_IDLE);

endmodule

`default_nettype wire

// ----- sv/program_flow_checkpoint_monitor.sv -----
// Program flow checkpoint monitor: top level with config registers, input
// stage and result register. Depends on pfcm_pkg and pfcm_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one event: action_i (0 checkpoint
//   reached, 1 restart), sequence_id_i and checkpoint_id_i. Output channel
//   (out_valid_o/out_ready_i) returns one result per event: status_o,
//   active_instance_o and current_checkpoint_o.
//   The result is registered from the input register through the check logic. One
//   event per cycle is sustained while no refresh runs and results are taken,
//   since the whole check and store update is one pass of logic between them.
//   Length registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i. Each
//   write starts a refresh of the cached next checkpoint of every entry through
//   a shared 9-step remainder unit, one entry after another; no event is
//   processed while the refresh runs.
//   Reset loads lengths of 4, clears all instances and the error latch.
//   When the receiver stalls, the result register holds and the input stage
//   takes one more event; then in_ready_o drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module program_flow_checkpoint_monitor #(
  parameter int unsigned NUM_SEQUENCES = 4,
  parameter int unsigned MAX_PARALLEL  = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pfcm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pfcm_pkg::CP_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              action_i,
  input  wire logic [pfcm_pkg::SEQ_W-1:0]        sequence_id_i,
  input  wire logic [pfcm_pkg::CP_W-1:0]         checkpoint_id_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [pfcm_pkg::STATUS_W-1:0]          status_o,
  output logic [pfcm_pkg::INST_W-1:0]            active_instance_o,
  output logic [pfcm_pkg::CP_W-1:0]              current_checkpoint_o
);

  logic [pfcm_pkg::NUM_LEN_REGS-1:0][pfcm_pkg::CP_W-1:0] seq_len_q;

  logic                         in_valid_q;
  logic                         action_q;
  logic [pfcm_pkg::SEQ_W-1:0]   seq_q;
  logic [pfcm_pkg::CP_W-1:0]    cp_q;

  logic                         out_valid_q;
  pfcm_pkg::result_t            result_q;
  pfcm_pkg::result_t            core_result;
  logic                         core_busy;
  logic                         step_fire;

  assign step_fire  = in_valid_q && !core_busy && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pfcm_pkg::NUM_LEN_REGS; k++) begin
        seq_len_q[k] <= pfcm_pkg::LEN_RESET;
      end
    end else if (cfg_we_i) begin
      seq_len_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      seq_q    <= sequence_id_i;
      cp_q     <= checkpoint_id_i;
    end
  end

  pfcm_core #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .MAX_PARALLEL  (MAX_PARALLEL)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seq_len_i       (seq_len_q),
    .cfg_we_i        (cfg_we_i),
    .step_i          (step_fire),
    .action_i        (action_q),
    .sequence_id_i   (seq_q),
    .checkpoint_id_i (cp_q),
    .busy_o          (core_busy),
    .result_o        (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = result_q.status;
  assign active_instance_o    = result_q.active_instance;
  assign current_checkpoint_o = result_q.current_checkpoint;

  // held event survives until processed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step_fire |=> in_valid_q && $stable(cp_q) && $stable(seq_q))
    else $error("pending event lost");

  // a length write always launches the cache refresh
  a_cfg_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> core_busy)
    else $error("length write did not start refresh");

  a_restart_inst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pfcm_pkg::ST_RESTARTED |-> active_instance_o == '0)
    else $error("restart result with nonzero instance");

  a_new_inst_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pfcm_pkg::ST_NEW_INSTANCE |-> current_checkpoint_o == '0)
    else $error("new instance not at checkpoint zero");

endmodule

`default_nettype wire
